// ----- rtl/mlk_pkg.sv -----
// Shared types, constants and the Morse table for the letter keyer.
`timescale 1ns / 1ps
package mlk_pkg;

	localparam int CHAR_W = 8;
	localparam int DUR_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DOT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DASH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP = 2'd2;

	// Register reset values
	localparam logic [DUR_W-1:0] DOT_RESET = 16'd200;
	localparam logic [DUR_W-1:0] DASH_RESET = 16'd600;
	localparam logic [DUR_W-1:0] GAP_RESET = 16'd100;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

	// One classified letter: symbol count and pattern, first symbol at bit count-1
	typedef struct packed {
		logic [2:0] count;
		logic [3:0] pattern;
	} mlk_entry_t;

	// Interval lengths from the configuration registers
	typedef struct packed {
		logic [DUR_W-1:0] dot;
		logic [DUR_W-1:0] dash;
		logic [DUR_W-1:0] gap;
	} mlk_cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ON,
		BK_OFF,
		BK_GAP
	} mlk_state_t;

	// Morse table: count in bits 6..4, pattern in bits 3..0, a one bit is a dash
	function automatic mlk_entry_t morse_lookup(input logic [4:0] idx);
		logic [7:0] code;
		mlk_entry_t e;
		case (idx)
			5'd0: code = 8'h21;
			5'd1: code = 8'h48;
			5'd2: code = 8'h4A;
			5'd3: code = 8'h34;
			5'd4: code = 8'h10;
			5'd5: code = 8'h42;
			5'd6: code = 8'h36;
			5'd7: code = 8'h40;
			5'd8: code = 8'h20;
			5'd9: code = 8'h47;
			5'd10: code = 8'h35;
			5'd11: code = 8'h44;
			5'd12: code = 8'h23;
			5'd13: code = 8'h22;
			5'd14: code = 8'h37;
			5'd15: code = 8'h46;
			5'd16: code = 8'h4D;
			5'd17: code = 8'h32;
			5'd18: code = 8'h30;
			5'd19: code = 8'h11;
			5'd20: code = 8'h31;
			5'd21: code = 8'h41;
			5'd22: code = 8'h33;
			5'd23: code = 8'h49;
			5'd24: code = 8'h4B;
			5'd25: code = 8'h4C;
			default: code = 8'h10;
		endcase
		e.count = code[6:4];
		e.pattern = code[3:0];
		return e;
	endfunction

endpackage

// ----- rtl/mlk_front.sv -----
// Front end: takes a character request, folds case, classifies and looks up the letter.
`timescale 1ns / 1ps
module mlk_front
	import mlk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CHAR_W-1:0] char_code,
	output logic              busy,
	output logic              push_valid,
	output mlk_entry_t        push_entry,
	input  logic              push_ready
);

	logic              valid_s1;
	mlk_entry_t        entry_s1;
	logic [CHAR_W-1:0] upper;
	logic [CHAR_W-1:0] offset;
	logic              is_letter;
	logic              accept;

	// Fold lower case and check for a letter
	always_comb begin
		if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) begin
			upper = char_code - CASE_OFFSET;
		end else begin
			upper = char_code;
		end
		is_letter = (upper >= CHAR_UPPER_A) && (upper <= CHAR_UPPER_Z);
		offset = upper - CHAR_UPPER_A;
	end

	assign busy = valid_s1 && !push_ready;
	assign accept = start && !busy;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	// Hold the classified letter until the queue takes it; drop non-letters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= is_letter;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= morse_lookup(offset[4:0]);
		end
	end

endmodule

// ----- rtl/mlk_queue.sv -----
// Short queue of classified letters between front and back end.
`timescale 1ns / 1ps
module mlk_queue
	import mlk_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  mlk_entry_t push_entry,
	output logic       push_ready,
	output logic       pop_valid,
	output mlk_entry_t pop_entry,
	input  logic       pop_ready
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	mlk_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_FULL);
	assign pop_valid = (cnt_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/mlk_back.sv -----
// Back end: plays letters as on, off and gap intervals, one per cycle while keying.
`timescale 1ns / 1ps
module mlk_back
	import mlk_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mlk_cfg_t         cfg,
	input  logic             pop_valid,
	input  mlk_entry_t       pop_entry,
	output logic             pop_ready,
	output logic             strobe,
	output logic             led_on,
	output logic [DUR_W-1:0] duration_ms,
	output logic             last
);

	mlk_state_t state_q;
	mlk_state_t state_d;
	logic [3:0] pattern_q;
	logic [1:0] idx_q;
	logic       dash;
	logic       load;

	assign dash = pattern_q[idx_q];
	assign load = pop_valid && pop_ready;

	// Next state and result outputs
	always_comb begin
		state_d = state_q;
		pop_ready = 1'b0;
		strobe = 1'b0;
		led_on = 1'b0;
		last = 1'b0;
		duration_ms = dash ? cfg.dash : cfg.dot;
		case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = BK_ON;
				end
			end
			BK_ON: begin
				strobe = 1'b1;
				led_on = 1'b1;
				state_d = BK_OFF;
			end
			BK_OFF: begin
				strobe = 1'b1;
				state_d = (idx_q == 2'd0) ? BK_GAP : BK_ON;
			end
			BK_GAP: begin
				strobe = 1'b1;
				last = 1'b1;
				duration_ms = cfg.gap;
				pop_ready = 1'b1;
				state_d = pop_valid ? BK_ON : BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Load a new letter, step down one symbol after each off interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= pop_entry.count[1:0] - 2'd1;
		end else if (state_q == BK_OFF && idx_q != 2'd0) begin
			idx_q <= idx_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pattern_q <= pop_entry.pattern;
		end
	end

endmodule

// ----- rtl/morse_letter_keyer_core.sv -----
// Morse letter keyer: configuration registers, front end, letter queue and back end.
// A letter passes the front stage, the queue and the back end's state register before
// its first interval shows. Results come one per cycle while a letter plays; the back
// end keys an on and off pair per symbol and a closing gap; non-letters key nothing.
// busy rises when the letter queue and the front stage are both full.
// Reset clears the queue, the sequencer and sets dot 200, dash 600, gap 100 ms.
`timescale 1ns / 1ps
module morse_letter_keyer_core
	import mlk_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CHAR_W-1:0]    char_code,
	output logic                 strobe,
	output logic                 led_on,
	output logic [DUR_W-1:0]     duration_ms,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_data
);

	mlk_cfg_t   cfg_q;
	logic       push_valid;
	logic       push_ready;
	mlk_entry_t push_entry;
	logic       pop_valid;
	logic       pop_ready;
	mlk_entry_t pop_entry;

	assign cfg_ready = 1'b1;

	// Write configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot <= DOT_RESET;
			cfg_q.dash <= DASH_RESET;
			cfg_q.gap <= GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DOT: cfg_q.dot <= cfg_data;
				REG_DASH: cfg_q.dash <= cfg_data;
				REG_GAP: cfg_q.gap <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mlk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.char_code  (char_code),
		.busy       (busy),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	mlk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	mlk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop_valid   (pop_valid),
		.pop_entry   (pop_entry),
		.pop_ready   (pop_ready),
		.strobe      (strobe),
		.led_on      (led_on),
		.duration_ms (duration_ms),
		.last        (last)
	);

endmodule

// ----- rtl/mlk_checker.sv -----
// Port-level checks on the keyer's result sequence, bound to the top level.
`timescale 1ns / 1ps
module mlk_checker
	import mlk_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             strobe,
	input logic             led_on,
	input logic [DUR_W-1:0] duration_ms,
	input logic             last
);

	// The closing gap of a letter is always a dark interval
	a_gap_dark: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !led_on)
		else $error("letter gap shown with LED on");

	// An on interval is followed at once by a dark one of the same length
	a_on_then_off: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && led_on |=> strobe && !led_on && !last
			&& duration_ms == $past(duration_ms))
		else $error("on interval not followed by matching off interval");

	// Results of one letter come without a break until the gap
	a_no_break: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("letter sequence broken before its gap");

endmodule

bind morse_letter_keyer_core mlk_checker u_mlk_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the Morse letter keyer core.
`timescale 1ns / 1ps
module tb;
	import mlk_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_LIMIT = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// One keyed interval as it shows on the result ports
	typedef struct packed {
		logic             led;
		logic [DUR_W-1:0] len;
		logic             fin;
	} interval_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [CHAR_W-1:0]    char_code = '0;
	logic                 strobe;
	logic                 led_on;
	logic [DUR_W-1:0]     duration_ms;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DUR_W-1:0]     cfg_data = '0;

	// Local copy of the interval lengths
	logic [DUR_W-1:0] dot_ms = DOT_RESET;
	logic [DUR_W-1:0] dash_ms = DASH_RESET;
	logic [DUR_W-1:0] gap_ms = GAP_RESET;

	logic [CHAR_W-1:0] letters_to_key[$];
	interval_t         intervals_due[$];
	logic              request_taken = 1'b0;
	int                send_idle_pct = 0;
	int                fail_count = 0;
	int                quiet_cycles = 0;

	morse_letter_keyer_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.char_code   (char_code),
		.strobe      (strobe),
		.led_on      (led_on),
		.duration_ms (duration_ms),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Dot and dash spelling of an upper-case letter
	function automatic string morse_symbols(input logic [CHAR_W-1:0] letter);
		case (letter)
			"A": return ".-";
			"B": return "-...";
			"C": return "-.-.";
			"D": return "-..";
			"E": return ".";
			"F": return "..-.";
			"G": return "--.";
			"H": return "....";
			"I": return "..";
			"J": return ".---";
			"K": return "-.-";
			"L": return ".-..";
			"M": return "--";
			"N": return "-.";
			"O": return "---";
			"P": return ".--.";
			"Q": return "--.-";
			"R": return ".-.";
			"S": return "...";
			"T": return "-";
			"U": return "..-";
			"V": return "...-";
			"W": return ".--";
			"X": return "-..-";
			"Y": return "-.--";
			"Z": return "--..";
			default: return "";
		endcase
	endfunction

	// Queue the on/off pairs and the closing gap that a request keys
	task automatic predict_keying(input logic [CHAR_W-1:0] code);
		logic [CHAR_W-1:0] letter;
		logic [DUR_W-1:0]  len;
		string             syms;
		int                k;
		letter = code;
		if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
			letter = code - CASE_OFFSET;
		end
		if (letter >= CHAR_UPPER_A && letter <= CHAR_UPPER_Z) begin
			syms = morse_symbols(letter);
			for (k = 0; k < syms.len(); k++) begin
				len = (syms[k] == "-") ? dash_ms : dot_ms;
				intervals_due.push_back('{led: 1'b1, len: len, fin: 1'b0});
				intervals_due.push_back('{led: 1'b0, len: len, fin: 1'b0});
			end
			intervals_due.push_back('{led: 1'b0, len: gap_ms, fin: 1'b1});
		end
	endtask

	// Drive requests: hold an offered one until taken, otherwise idle at random
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || request_taken) begin
			if (letters_to_key.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				start <= 1'b1;
				char_code <= letters_to_key[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Take requests and predict their intervals
	always @(posedge clk) begin
		request_taken <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			predict_keying(char_code);
			void'(letters_to_key.pop_front());
		end
	end

	// Check every strobed interval against the oldest prediction
	always @(posedge clk) begin : check_intervals
		interval_t want;
		if (arst_n && strobe) begin
			if (intervals_due.size() == 0) begin
				if (fail_count < REPORT_LIMIT) begin
					$display("unexpected interval: led_on %0b duration_ms %0d last %0b",
						led_on, duration_ms, last);
				end
				fail_count = fail_count + 1;
			end else begin
				want = intervals_due.pop_front();
				if (led_on !== want.led || duration_ms !== want.len || last !== want.fin) begin
					if (fail_count < REPORT_LIMIT) begin
						$write("interval mismatch: exp led_on %0b duration_ms %0d last %0b, ",
							want.led, want.len, want.fin);
						$display("got led_on %0b duration_ms %0d last %0b",
							led_on, duration_ms, last);
					end
					fail_count = fail_count + 1;
				end
			end
		end
	end

	// Stop a run that stalls with nothing moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Write one register and mirror it once the channel takes it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DOT: dot_ms = value;
			REG_DASH: dash_ms = value;
			REG_GAP: gap_ms = value;
			default: ;
		endcase
	endtask

	task automatic write_lengths(input logic [DUR_W-1:0] dot, input logic [DUR_W-1:0] dash,
		input logic [DUR_W-1:0] gap);
		write_reg(REG_DOT, dot);
		write_reg(REG_DASH, dash);
		write_reg(REG_GAP, gap);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly letters of either case, the rest any byte
	task automatic queue_random(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < 80) begin
				letters_to_key.push_back(CHAR_W'($urandom_range(25)) +
					($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A));
			end else begin
				letters_to_key.push_back(CHAR_W'($urandom_range(255)));
			end
		end
	endtask

	// Wait until every request is keyed, then let the pipeline settle
	task automatic drain;
		while (letters_to_key.size() != 0 || intervals_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		string directed;
		int    i;
		directed = "AZaz@[`{ETHOMSQYJK";
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset lengths, no idling: letter edges, case folding, neighbors of the ranges
		send_idle_pct = 0;
		letters_to_key.push_back(8'h00);
		letters_to_key.push_back(8'hFF);
		for (i = 0; i < directed.len(); i++) begin
			letters_to_key.push_back(directed[i]);
		end
		queue_random(22);
		drain();

		// Zero dot and gap, longest dash; sparse requests
		write_lengths(16'h0000, 16'hFFFF, 16'h0000);
		send_idle_pct = 84;
		letters_to_key.push_back("T");
		letters_to_key.push_back("e");
		queue_random(40);
		drain();

		// Longest dot and gap, zero dash; an out-of-range index must change nothing
		write_lengths(16'hFFFF, 16'h0000, 16'hFFFF);
		write_reg(REG_UNUSED, DUR_W'($urandom_range(16'hFFFF)));
		@(negedge clk);
		cfg_valid <= 1'b0;
		send_idle_pct = 11;
		queue_random(42);
		drain();

		// Random lengths, back-to-back requests
		write_lengths(DUR_W'($urandom_range(16'hFFFF)), DUR_W'($urandom_range(16'hFFFF)),
			DUR_W'($urandom_range(16'hFFFF)));
		send_idle_pct = 0;
		queue_random(42);
		drain();

		// Random lengths, sparse requests
		write_lengths(DUR_W'($urandom_range(16'hFFFF)), DUR_W'($urandom_range(16'hFFFF)),
			DUR_W'($urandom_range(16'hFFFF)));
		send_idle_pct = 84;
		queue_random(42);
		drain();

		if (intervals_due.size() != 0) begin
			fail_count = fail_count + 1;
		end
		if (fail_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
